// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled in reset.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- sv/gdfs_pkg.sv -----
// ----------------------------------------------------------------------------
// gdfs_pkg
// Types and constants of the grid depth-first path search.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int STACK_DEPTH = 4096;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int CELL_W      = ROW_W + COL_W;
  localparam int NCELLS      = MAX_ROWS * MAX_COLS;
  localparam int SP_W        = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_FETCH = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_ACK = 3'd0,
    KIND_SUMMARY = 3'd1,
    KIND_VISIT = 3'd2,
    KIND_PATH = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    REG_ROWS = 3'd0,
    REG_COLS = 3'd1,
    REG_START_ROW = 3'd2,
    REG_START_COL = 3'd3,
    REG_GOAL_ROW = 3'd4,
    REG_GOAL_COL = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    DIR_UP = 2'd0,
    DIR_LEFT = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN = 2'd3
  } dir_e;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       cell_wall;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        found;
    logic [12:0] visited_count;
    logic [11:0] path_steps;
    logic [5:0]  out_row;
    logic [5:0]  out_col;
    logic        last;
  } out_item_t;

endpackage

// ----- sv/grid_dfs_path_search.sv -----
// ----------------------------------------------------------------------------
// grid_dfs_path_search
// Depth-first search over a stored wall grid, with visit and path readout.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries one command per transaction:
// cell write, search, or fetch. Every command yields one result transaction
// on out_valid_o/out_ready_i. Unchecked by the block, the user must write
// configuration via cfg_we_i, cfg_idx_i, cfg_data_i while the block is idle.
// A cell write answers from the output register; a fetch first reads the
// visit or path memory. A search first sweeps the visited memory, then pushes
// the start, pops cells and tries each of the four directions, pushing open,
// unvisited in-grid neighbors, until the stack empties or the goal is popped;
// a found goal is traced back to the start cell; the summary follows.
// One command is in flight at a time: in_ready_o
// drops from acceptance until its result is taken, set by the single
// read-modify-write sequencer around the grid memories.
// Reset clears configuration to a 1x1 grid, counters and read position;
// grid contents stay undefined until written.
// A stalled receiver holds the result in the output register and the block
// accepts nothing until it is taken.
// ----------------------------------------------------------------------------
module grid_dfs_path_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gdfs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gdfs_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [6:0]          cfg_data_i
);
  import gdfs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLEAR = 10'b0000000010,
    S_INIT  = 10'b0000000100,
    S_POP   = 10'b0000001000,
    S_POPW  = 10'b0000010000,
    S_NB    = 10'b0000100000,
    S_NBW   = 10'b0001000000,
    S_PREAD = 10'b0010000000,
    S_PSTEP = 10'b0100000000,
    S_FETCH = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [6:0] rows_q, cols_q;
  logic [ROW_W-1:0] srow_q, grow_q;
  logic [COL_W-1:0] scol_q, gcol_q;

  logic [CELL_W-1:0] clr_q, clr_d;
  logic [SP_W:0] top_q, top_d;
  logic [CELL_W:0] vt_q, vt_d, pt_q, pt_d, pn_q, pn_d;
  logic [CELL_W+1:0] rp_q, rp_d;
  logic found_q, found_d;
  logic [1:0] d_q, d_d;
  logic [CELL_W-1:0] u_q, u_d, nb_q, nb_d, cur_q, cur_d;
  logic [2:0] pk_q, pk_d;
  logic plast_q, plast_d;

  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // memories
  logic wall_mem [NCELLS];
  logic vis_mem [NCELLS];
  logic [1:0] dir_mem [NCELLS];
  logic [CELL_W-1:0] stack_mem [STACK_DEPTH];
  logic [CELL_W-1:0] visit_mem [NCELLS];
  logic [CELL_W-1:0] path_mem [NCELLS];

  logic wall_we, vis_we, dir_we, stack_we, visit_we, path_we;
  logic [CELL_W-1:0] wall_wa, vis_wa, dir_wa, visit_wa, path_wa;
  logic [SP_W-1:0] stack_wa, stack_ra;
  logic wall_wd, vis_wd;
  logic [1:0] dir_wd;
  logic [CELL_W-1:0] stack_wd, visit_wd, path_wd;
  logic [CELL_W-1:0] nb_ra, dir_ra, visit_ra, path_ra;
  logic wall_rd, vis_rd;
  logic [1:0] dir_rd;
  logic [CELL_W-1:0] stack_rd, visit_rd, path_rd;

  always_ff @(posedge clk_i) begin
    if (wall_we) wall_mem[wall_wa] <= wall_wd;
    wall_rd <= wall_mem[nb_ra];
  end
  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd <= vis_mem[nb_ra];
  end
  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    dir_rd <= dir_mem[dir_ra];
  end
  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    stack_rd <= stack_mem[stack_ra];
  end
  always_ff @(posedge clk_i) begin
    if (visit_we) visit_mem[visit_wa] <= visit_wd;
    visit_rd <= visit_mem[visit_ra];
  end
  always_ff @(posedge clk_i) begin
    if (path_we) path_mem[path_wa] <= path_wd;
    path_rd <= path_mem[path_ra];
  end

  // grid limits, saturated
  logic [6:0] lim_r, lim_c;
  assign lim_r = (rows_q > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_q;
  assign lim_c = (cols_q > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_q;

  logic [ROW_W-1:0] u_row, cur_row;
  logic [COL_W-1:0] u_col, cur_col;
  assign u_row = u_q[CELL_W-1:COL_W];
  assign u_col = u_q[COL_W-1:0];
  assign cur_row = cur_q[CELL_W-1:COL_W];
  assign cur_col = cur_q[COL_W-1:0];

  // neighbor of u in direction d_q
  logic nb_ok;
  logic [ROW_W-1:0] nb_row;
  logic [COL_W-1:0] nb_col;
  always_comb begin
    nb_row = u_row;
    nb_col = u_col;
    nb_ok = 1'b0;
    unique case (dir_e'(d_q))
      DIR_UP: begin
        nb_row = u_row - 1'b1;
        nb_ok = (u_row != '0);
      end
      DIR_LEFT: begin
        nb_col = u_col - 1'b1;
        nb_ok = (u_col != '0);
      end
      DIR_RIGHT: begin
        nb_col = u_col + 1'b1;
        nb_ok = ({1'b0, u_col} + 7'd1) < lim_c;
      end
      DIR_DOWN: begin
        nb_row = u_row + 1'b1;
        nb_ok = ({1'b0, u_row} + 7'd1) < lim_r;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // parent of cur from its arrival mark
  logic par_ok;
  logic [ROW_W-1:0] par_row;
  logic [COL_W-1:0] par_col;
  always_comb begin
    par_row = cur_row;
    par_col = cur_col;
    par_ok = 1'b0;
    unique case (dir_e'(dir_rd))
      DIR_UP: begin
        par_row = cur_row + 1'b1;
        par_ok = (cur_row != '1);
      end
      DIR_LEFT: begin
        par_col = cur_col + 1'b1;
        par_ok = (cur_col != '1);
      end
      DIR_RIGHT: begin
        par_col = cur_col - 1'b1;
        par_ok = (cur_col != '0);
      end
      DIR_DOWN: begin
        par_row = cur_row - 1'b1;
        par_ok = (cur_row != '0);
      end
      default: par_ok = 1'b0;
    endcase
  end

  logic [CELL_W-1:0] start_cell;
  assign start_cell = {srow_q, scol_q};

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc = in_valid_i && in_ready_o;

  logic [CELL_W+1:0] k_idx;
  assign k_idx = rp_q - {1'b0, vt_q};

  function automatic out_item_t mk_out(input logic [2:0] kind, input logic fnd,
                                       input logic [CELL_W:0] vt,
                                       input logic [CELL_W:0] pt,
                                       input logic [CELL_W-1:0] cell_id,
                                       input logic lst);
    out_item_t o;
    o.kind = kind;
    o.found = fnd;
    o.visited_count = 13'(vt);
    o.path_steps = (fnd && pt != '0) ? 12'(pt - 1'b1) : 12'd0;
    o.out_row = 6'(cell_id[CELL_W-1:COL_W]);
    o.out_col = 6'(cell_id[COL_W-1:0]);
    o.last = lst;
    return o;
  endfunction

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    top_d = top_q;
    vt_d = vt_q;
    pt_d = pt_q;
    pn_d = pn_q;
    rp_d = rp_q;
    found_d = found_q;
    d_d = d_q;
    u_d = u_q;
    nb_d = nb_q;
    cur_d = cur_q;
    pk_d = pk_q;
    plast_d = plast_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;

    wall_we = 1'b0;
    wall_wa = {in_data_i.cell_row, in_data_i.cell_col};
    wall_wd = in_data_i.cell_wall;
    vis_we = 1'b0;
    vis_wa = nb_q;
    vis_wd = 1'b1;
    dir_we = 1'b0;
    dir_wa = nb_q;
    dir_wd = d_q;
    stack_we = 1'b0;
    stack_wa = top_q[SP_W-1:0];
    stack_wd = nb_q;
    visit_we = 1'b0;
    visit_wa = vt_q[CELL_W-1:0];
    visit_wd = stack_rd;
    path_we = 1'b0;
    path_wa = 12'(pn_q - 1'b1);
    path_wd = cur_q;
    nb_ra = {nb_row, nb_col};
    dir_ra = cur_q;
    stack_ra = SP_W'(top_q - 1'b1);
    visit_ra = rp_q[CELL_W-1:0];
    path_ra = 12'(pt_q - 1'b1 - k_idx[CELL_W:0]);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (func_e'(in_data_i.func))
            FUNC_WRITE: begin
              wall_we = 1'b1;
              out_valid_d = 1'b1;
              out_d = mk_out(KIND_ACK, found_q, vt_q, pt_q, '0, 1'b0);
            end
            FUNC_SEARCH: begin
              clr_d = '0;
              vt_d = '0;
              pt_d = '0;
              found_d = 1'b0;
              rp_d = '0;
              top_d = '0;
              state_d = S_CLEAR;
            end
            FUNC_FETCH: begin
              if (rp_q < {1'b0, vt_q}) begin
                pk_d = KIND_VISIT;
                plast_d = (rp_q + 1'b1) == {1'b0, vt_q};
                rp_d = rp_q + 1'b1;
                state_d = S_FETCH;
              end else if (k_idx < {1'b0, pt_q}) begin
                pk_d = KIND_PATH;
                plast_d = (k_idx + 1'b1) == {1'b0, pt_q};
                rp_d = rp_q + 1'b1;
                state_d = S_FETCH;
              end else begin
                out_valid_d = 1'b1;
                out_d = mk_out(KIND_EMPTY, found_q, vt_q, pt_q, '0, 1'b0);
              end
            end
            default: begin
              out_valid_d = 1'b1;
              out_d = mk_out(KIND_EMPTY, found_q, vt_q, pt_q, '0, 1'b0);
            end
          endcase
        end
      end
      S_FETCH: begin
        out_valid_d = 1'b1;
        out_d = mk_out(pk_q, found_q, vt_q, pt_q,
                       (pk_q == KIND_VISIT) ? visit_rd : path_rd, plast_q);
        state_d = S_IDLE;
      end
      S_CLEAR: begin
        vis_we = 1'b1;
        vis_wa = clr_q;
        vis_wd = 1'b0;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) state_d = S_INIT;
      end
      S_INIT: begin
        if ({1'b0, srow_q} >= lim_r || {1'b0, scol_q} >= lim_c) begin
          out_valid_d = 1'b1;
          out_d = mk_out(KIND_SUMMARY, 1'b0, '0, '0, '0, 1'b0);
          state_d = S_IDLE;
        end else begin
          vis_we = 1'b1;
          vis_wa = start_cell;
          stack_we = 1'b1;
          stack_wa = '0;
          stack_wd = start_cell;
          top_d = (SP_W+1)'(1);
          state_d = S_POP;
        end
      end
      S_POP: begin
        if (top_q == '0) begin
          out_valid_d = 1'b1;
          out_d = mk_out(KIND_SUMMARY, 1'b0, vt_q, '0, '0, 1'b0);
          state_d = S_IDLE;
        end else begin
          top_d = top_q - 1'b1;
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        visit_we = 1'b1;
        vt_d = vt_q + 1'b1;
        u_d = stack_rd;
        d_d = DIR_UP;
        if (stack_rd == {grow_q, gcol_q}) begin
          found_d = 1'b1;
          cur_d = stack_rd;
          pn_d = (CELL_W+1)'(1);
          state_d = S_PREAD;
        end else begin
          state_d = S_NB;
        end
      end
      S_NB: begin
        nb_d = {nb_row, nb_col};
        if (nb_ok) begin
          state_d = S_NBW;
        end else if (d_q == DIR_DOWN) begin
          state_d = S_POP;
        end else begin
          d_d = d_q + 1'b1;
        end
      end
      S_NBW: begin
        if (!wall_rd && !vis_rd && top_q < (SP_W+1)'(STACK_DEPTH)) begin
          vis_we = 1'b1;
          dir_we = 1'b1;
          stack_we = 1'b1;
          top_d = top_q + 1'b1;
        end
        d_d = d_q + 1'b1;
        state_d = (d_q == DIR_DOWN) ? S_POP : S_NB;
      end
      S_PREAD: begin
        path_we = 1'b1;
        if (cur_q == start_cell || pn_q == (CELL_W+1)'(NCELLS)) begin
          pt_d = pn_q;
          out_valid_d = 1'b1;
          out_d = mk_out(KIND_SUMMARY, 1'b1, vt_q, pn_q, '0, 1'b0);
          state_d = S_IDLE;
        end else begin
          state_d = S_PSTEP;
        end
      end
      S_PSTEP: begin
        if (!par_ok) begin
          pt_d = pn_q;
          out_valid_d = 1'b1;
          out_d = mk_out(KIND_SUMMARY, 1'b1, vt_q, pn_q, '0, 1'b0);
          state_d = S_IDLE;
        end else begin
          cur_d = {par_row, par_col};
          pn_d = pn_q + 1'b1;
          state_d = S_PREAD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      clr_q <= '0;
      top_q <= '0;
      vt_q <= '0;
      pt_q <= '0;
      pn_q <= '0;
      rp_q <= '0;
      found_q <= 1'b0;
      d_q <= '0;
      out_valid_q <= 1'b0;
      rows_q <= 7'd1;
      cols_q <= 7'd1;
      srow_q <= '0;
      scol_q <= '0;
      grow_q <= '0;
      gcol_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      top_q <= top_d;
      vt_q <= vt_d;
      pt_q <= pt_d;
      pn_q <= pn_d;
      rp_q <= rp_d;
      found_q <= found_d;
      d_q <= d_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ROWS: rows_q <= cfg_data_i;
          REG_COLS: cols_q <= cfg_data_i;
          REG_START_ROW: srow_q <= cfg_data_i[5:0];
          REG_START_COL: scol_q <= cfg_data_i[5:0];
          REG_GOAL_ROW: grow_q <= cfg_data_i[5:0];
          REG_GOAL_COL: gcol_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    nb_q <= nb_d;
    cur_q <= cur_d;
    pk_q <= pk_d;
    plast_q <= plast_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ----- sv/gdfs_checker.sv -----
// ----------------------------------------------------------------------------
// gdfs_checker
// Port-level checks of the grid depth-first path search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module gdfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input gdfs_pkg::out_item_t out_data_o
);
  import gdfs_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_SAME(a_kind_range, clk_i, rst_ni, out_valid_o, out_data_o.kind <= KIND_EMPTY)
  `ASSERT_SAME(a_no_cell, clk_i, rst_ni,
    out_valid_o && out_data_o.kind != KIND_VISIT && out_data_o.kind != KIND_PATH,
    out_data_o.out_row == '0 && out_data_o.out_col == '0 && !out_data_o.last)
  `ASSERT_SAME(a_steps_found, clk_i, rst_ni, out_valid_o && out_data_o.path_steps != '0,
    out_data_o.found)

endmodule

bind grid_dfs_path_search gdfs_checker u_gdfs_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o(out_data_o)
);
